/* rtl/image_frame_deframer_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the image frame deframer
// Concurrent property wrappers that report through $error.
// ---------------------------------------------------------------------------
`ifndef IMAGE_FRAME_DEFRAMER_MACROS_SVH
`define IMAGE_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define IFD_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("ifd assertion failed");

// next-cycle implication, disabled while reset is high
`define IFD_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("ifd assertion failed");

`endif

/* rtl/ifd_pkg.sv */
// ---------------------------------------------------------------------------
// ifd_pkg
// Shared types, codes and constants of the image frame deframer.
// ---------------------------------------------------------------------------
package ifd_pkg;

   localparam int MAGIC_LENGTH   = 23;
   localparam int MAX_EXT_LENGTH = 8;

   localparam logic [7:0]  NEWLINE          = 8'h0A;
   localparam logic [31:0] MAX_IMAGE_RESET  = 32'd16777216;
   localparam logic [32:0] PAYLOAD_SAT      = {33{1'b1}};

   // magic bytes, zero beyond the magic length
   localparam logic [7:0] MAGIC_TABLE [0:31] = '{
      8'h00, 8'h45, 8'h54, 8'h5F, 8'h43, 8'h4C, 8'h49, 8'h50,
      8'h42, 8'h4F, 8'h41, 8'h52, 8'h44, 8'h5F, 8'h49, 8'h4D,
      8'h41, 8'h47, 8'h45, 8'h5F, 8'h56, 8'h31, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // word kinds on the result side
   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_EXT     = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;

   // verdict codes
   localparam logic [2:0] ERR_OK          = 3'd0;
   localparam logic [2:0] ERR_NO_EXT_NL   = 3'd1;
   localparam logic [2:0] ERR_BAD_EXT     = 3'd2;
   localparam logic [2:0] ERR_NO_SIZE_NL  = 3'd3;
   localparam logic [2:0] ERR_BAD_SIZE    = 3'd4;
   localparam logic [2:0] ERR_SIZE_RANGE  = 3'd5;
   localparam logic [2:0] ERR_LENGTH      = 3'd6;

   // classified input word
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       is_newline;
      logic       is_digit;
      logic       is_alnum;
   } item_class_type;

   // one result word
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic        frame_done;
      logic        is_frame;
      logic [2:0]  error_code;
      logic [31:0] image_size;
      logic [3:0]  ext_length;
   } result_type;

endpackage

/* rtl/ifd_front.sv */
// ---------------------------------------------------------------------------
// ifd_front
// Classifies each incoming byte ahead of the item queue.
// ---------------------------------------------------------------------------
module ifd_front (
   input  logic [7:0]              in_byte,
   input  logic                    in_last,
   output ifd_pkg::item_class_type item
);
   import ifd_pkg::*;

   logic is_digit;
   logic is_upper;
   logic is_lower;

   assign is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
   assign is_upper = (in_byte >= 8'h41) && (in_byte <= 8'h5A);
   assign is_lower = (in_byte >= 8'h61) && (in_byte <= 8'h7A);

   always_comb begin
      item.data       = in_byte;
      item.last       = in_last;
      item.is_newline = (in_byte == NEWLINE);
      item.is_digit   = is_digit;
      item.is_alnum   = is_digit || is_upper || is_lower;
   end

endmodule

/* rtl/ifd_queue.sv */
// ---------------------------------------------------------------------------
// ifd_queue
// Two-word queue of classified bytes between the front and the back end.
// ---------------------------------------------------------------------------
module ifd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ifd_pkg::item_class_type push_item,
   output logic                    full,
   input  logic                    pop,
   output ifd_pkg::item_class_type pop_item,
   output logic                    empty
);
   import ifd_pkg::*;

   item_class_type slot_ff [0:1];
   logic [1:0]     count_ff, count_in;
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic           do_push;
   logic           do_pop;

   assign full     = count_ff[1];
   assign empty    = (count_ff == 2'd0);
   assign pop_item = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/ifd_back.sv */
// ---------------------------------------------------------------------------
// ifd_back
// Frame parser: per-byte phase step, size accumulate, verdict and a
// two-word result buffer.
// ---------------------------------------------------------------------------
module ifd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [31:0]             csr_write_data,
   input  logic                    in_valid,
   input  ifd_pkg::item_class_type in_item,
   output logic                    in_pop,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output ifd_pkg::result_type     rsp_item
);
   import ifd_pkg::*;

   localparam logic [2:0] PH_MAGIC   = 3'd0;
   localparam logic [2:0] PH_EXT     = 3'd1;
   localparam logic [2:0] PH_SIZE    = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_DRAIN   = 3'd4;

   localparam logic [5:0] MAGIC_END   = 6'(MAGIC_LENGTH);
   localparam logic [3:0] EXT_LIMIT   = 4'(MAX_EXT_LENGTH);

   logic [31:0] max_image_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  magic_index_ff, magic_index_in;
   logic [3:0]  ext_count_ff, ext_count_in;
   logic        ext_bad_ff, ext_bad_in;
   logic [63:0] size_accum_ff, size_accum_in;
   logic        size_digit_ff, size_digit_in;
   logic        size_nondigit_ff, size_nondigit_in;
   logic        size_over_ff, size_over_in;
   logic [32:0] payload_count_ff, payload_count_in;
   logic [2:0]  sticky_error_ff, sticky_error_in;
   logic        not_frame_ff, not_frame_in;

   logic [67:0] accum_step;
   logic        advance;
   result_type  result;

   result_type  slot_ff [0:1];
   logic [1:0]  count_ff, count_in;
   logic        wr_ptr_ff, rd_ptr_ff;
   logic        rbuf_full;
   logic        do_read;

   assign rbuf_full = count_ff[1];
   assign advance   = in_valid && !rbuf_full;
   assign in_pop    = advance;

   // accum * 10 + digit, carried wide to catch overflow past 64 bits
   assign accum_step = ({4'b0, size_accum_ff} << 3) + ({4'b0, size_accum_ff} << 1)
                     + 68'(in_item.data[3:0]);

   always_comb begin
      phase_in         = phase_ff;
      magic_index_in   = magic_index_ff;
      ext_count_in     = ext_count_ff;
      ext_bad_in       = ext_bad_ff;
      size_accum_in    = size_accum_ff;
      size_digit_in    = size_digit_ff;
      size_nondigit_in = size_nondigit_ff;
      size_over_in     = size_over_ff;
      payload_count_in = payload_count_ff;
      sticky_error_in  = sticky_error_ff;
      not_frame_in     = not_frame_ff;

      result            = '0;
      result.frame_done = in_item.last;

      unique case (phase_ff)
         PH_MAGIC: begin
            if (in_item.data != MAGIC_TABLE[magic_index_ff]) begin
               not_frame_in = 1'b1;
               phase_in     = PH_DRAIN;
            end else begin
               magic_index_in = magic_index_ff + 5'd1;
               if (magic_index_in == 5'd0 || {1'b0, magic_index_in} >= MAGIC_END) begin
                  phase_in = PH_EXT;
               end
            end
         end
         PH_EXT: begin
            if (in_item.is_newline) begin
               if (ext_count_ff == 4'd0 || ext_bad_ff) begin
                  sticky_error_in = ERR_BAD_EXT;
                  phase_in        = PH_DRAIN;
               end else begin
                  phase_in = PH_SIZE;
               end
            end else begin
               result.kind = KIND_EXT;
               result.data = in_item.data;
               if (!in_item.is_alnum || ext_count_ff >= EXT_LIMIT) begin
                  ext_bad_in = 1'b1;
               end else begin
                  ext_count_in = ext_count_ff + 4'd1;
               end
            end
         end
         PH_SIZE: begin
            if (in_item.is_newline) begin
               if (!size_digit_ff || size_nondigit_ff || size_over_ff) begin
                  sticky_error_in = ERR_BAD_SIZE;
                  phase_in        = PH_DRAIN;
               end else if (size_accum_ff == 64'd0 ||
                            size_accum_ff > {32'd0, max_image_ff}) begin
                  sticky_error_in = ERR_SIZE_RANGE;
                  phase_in        = PH_DRAIN;
               end else begin
                  payload_count_in = 33'd0;
                  phase_in         = PH_PAYLOAD;
               end
            end else if (in_item.is_digit) begin
               size_digit_in = 1'b1;
               if (!size_over_ff) begin
                  if (accum_step[67:64] != 4'd0) begin
                     size_over_in = 1'b1;
                  end else begin
                     size_accum_in = accum_step[63:0];
                  end
               end
            end else begin
               size_nondigit_in = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            result.kind = KIND_PAYLOAD;
            result.data = in_item.data;
            if (payload_count_ff != PAYLOAD_SAT) begin
               payload_count_in = payload_count_ff + 33'd1;
            end
         end
         default: begin
         end
      endcase

      if (in_item.last) begin
         if (!(not_frame_in || phase_in == PH_MAGIC)) begin
            result.is_frame = 1'b1;
            unique case (phase_in)
               PH_EXT:     result.error_code = ERR_NO_EXT_NL;
               PH_SIZE:    result.error_code = ERR_NO_SIZE_NL;
               PH_PAYLOAD: result.error_code =
                  ({31'd0, payload_count_in} == size_accum_in) ? ERR_OK : ERR_LENGTH;
               default:    result.error_code = sticky_error_in;
            endcase
            if (result.error_code == ERR_OK) begin
               result.image_size = size_accum_in[31:0];
               result.ext_length = ext_count_in;
            end
         end
         // clear for the next frame
         phase_in         = PH_MAGIC;
         magic_index_in   = 5'd0;
         ext_count_in     = 4'd0;
         ext_bad_in       = 1'b0;
         size_accum_in    = 64'd0;
         size_digit_in    = 1'b0;
         size_nondigit_in = 1'b0;
         size_over_in     = 1'b0;
         payload_count_in = 33'd0;
         sticky_error_in  = ERR_OK;
         not_frame_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_image_ff <= MAX_IMAGE_RESET;
      end else if (csr_write_enable) begin
         max_image_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_MAGIC;
         magic_index_ff   <= 5'd0;
         ext_count_ff     <= 4'd0;
         ext_bad_ff       <= 1'b0;
         size_accum_ff    <= 64'd0;
         size_digit_ff    <= 1'b0;
         size_nondigit_ff <= 1'b0;
         size_over_ff     <= 1'b0;
         payload_count_ff <= 33'd0;
         sticky_error_ff  <= ERR_OK;
         not_frame_ff     <= 1'b0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         magic_index_ff   <= magic_index_in;
         ext_count_ff     <= ext_count_in;
         ext_bad_ff       <= ext_bad_in;
         size_accum_ff    <= size_accum_in;
         size_digit_ff    <= size_digit_in;
         size_nondigit_ff <= size_nondigit_in;
         size_over_ff     <= size_over_in;
         payload_count_ff <= payload_count_in;
         sticky_error_ff  <= sticky_error_in;
         not_frame_ff     <= not_frame_in;
      end
   end

   // result buffer
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_item  = slot_ff[rd_ptr_ff];
   assign do_read   = rsp_pop && !rsp_empty;
   assign count_in  = count_ff + 2'(advance) - 2'(do_read);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_ff ^ advance;
         rd_ptr_ff <= rd_ptr_ff ^ do_read;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

/* rtl/image_frame_deframer.sv */
// ---------------------------------------------------------------------------
// image_frame_deframer
// Parses framed image transfers one byte per word: magic, extension, size,
// payload, with a verdict word on the last byte of every frame.
//
// Input: push a byte with req_push while req_full is low; req_frame_end
// marks the last byte of a frame. Every accepted byte gives exactly one
// result word, in order, read with rsp_pop while rsp_empty is low.
// Extension and payload bytes come back in rsp_out_byte tagged by
// rsp_out_kind; the word for the last byte carries frame_done and verdict.
// A pushed byte is registered in the item queue, then the back end's step
// (64-bit multiply-by-ten accumulate and compares) writes its result word
// into the result buffer; one byte per cycle while that buffer has room.
// The csr port writes the largest accepted size; write it only while idle.
// Reset clears both queues and the parse state, and sets the size limit
// to 16777216. When the receiver stalls, the two-word result buffer fills,
// the back end holds, the two-word item queue fills and req_full rises.
// ---------------------------------------------------------------------------
module image_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_frame_end,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_done,
   output logic        rsp_is_frame,
   output logic [2:0]  rsp_error_code,
   output logic [31:0] rsp_image_size,
   output logic [3:0]  rsp_ext_length,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);
   import ifd_pkg::*;

   item_class_type front_item;
   item_class_type queue_item;
   logic           queue_empty;
   logic           back_pop;
   result_type     rsp_item;

   ifd_front u_front (
      .in_byte (req_in_byte),
      .in_last (req_frame_end),
      .item    (front_item)
   );

   ifd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (front_item),
      .full      (req_full),
      .pop       (back_pop),
      .pop_item  (queue_item),
      .empty     (queue_empty)
   );

   ifd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .in_valid         (!queue_empty),
      .in_item          (queue_item),
      .in_pop           (back_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_item         (rsp_item)
   );

   assign rsp_out_kind   = rsp_item.kind;
   assign rsp_out_byte   = rsp_item.data;
   assign rsp_frame_done = rsp_item.frame_done;
   assign rsp_is_frame   = rsp_item.is_frame;
   assign rsp_error_code = rsp_item.error_code;
   assign rsp_image_size = rsp_item.image_size;
   assign rsp_ext_length = rsp_item.ext_length;

endmodule

/* rtl/ifd_checker.sv */
// ---------------------------------------------------------------------------
// ifd_checker
// Port-level checks on the deframer's result words, bound to the top level.
// ---------------------------------------------------------------------------
`include "image_frame_deframer_macros.svh"

module ifd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [1:0]  rsp_out_kind,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_frame_done,
   input logic        rsp_is_frame,
   input logic [2:0]  rsp_error_code,
   input logic [31:0] rsp_image_size,
   input logic [3:0]  rsp_ext_length
);
   import ifd_pkg::*;

   logic        mid_word;
   logic        dirty_word;
   logic        size_clear;
   logic        verdict_clear;
   logic [50:0] word_bits;

   assign mid_word      = !rsp_empty && !rsp_frame_done;
   assign dirty_word    = !rsp_empty && (!rsp_is_frame || rsp_error_code != ERR_OK);
   assign size_clear    = (rsp_image_size == 32'd0) && (rsp_ext_length == 4'd0);
   assign verdict_clear = !rsp_is_frame && (rsp_error_code == ERR_OK) && size_clear;
   assign word_bits     = {rsp_out_kind, rsp_out_byte, rsp_frame_done, rsp_is_frame,
                           rsp_error_code, rsp_image_size, rsp_ext_length};

   // verdict fields stay quiet on words that do not end a frame
   `IFD_ASSERT_IMPLY(a_verdict_quiet, clock, reset, mid_word, verdict_clear)

   // size and extension length only on a clean frame
   `IFD_ASSERT_IMPLY(a_size_only_clean, clock, reset, dirty_word, size_clear)

   // a non-frame never reports an error
   `IFD_ASSERT_IMPLY(a_nonframe_no_error, clock, reset, !rsp_empty && !rsp_is_frame, rsp_error_code == ERR_OK)

   // no echo without a kind
   `IFD_ASSERT_IMPLY(a_echo_kind, clock, reset, !rsp_empty && rsp_out_kind == KIND_NONE, rsp_out_byte == 8'h00)

   // a stalled result word holds
   `IFD_ASSERT_NEXT(a_stall_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(word_bits))

endmodule

bind image_frame_deframer ifd_checker u_ifd_checker (.*);
